### rtl/ars_pkg.sv
`timescale 1ns / 1ps

package ars_pkg;

   localparam int SLOTS       = 8;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int ADDR_W      = 3;

   // operation codes
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_SUBMIT = 2'd1;
   localparam logic [1:0] FUNC_ACK    = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_TRANSMIT  = 3'd0;
   localparam logic [2:0] KIND_ACCEPTED  = 3'd1;
   localparam logic [2:0] KIND_REJECTED  = 3'd2;
   localparam logic [2:0] KIND_ACK_MATCH = 3'd3;
   localparam logic [2:0] KIND_ACK_NONE  = 3'd4;

   // register indexes
   localparam logic REG_RETRY_START = 1'b0;
   localparam logic REG_RETRY_MAX   = 1'b1;

   localparam logic [15:0] RETRY_START_RESET = 16'd500;
   localparam logic [23:0] RETRY_MAX_RESET   = 24'd8000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  slot;
      logic [31:0] tag;
      logic [3:0]  out_type;
      logic        is_retry;
      logic        last;
   } res_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // latch a new item, restart the walk
      logic step;       // examine the slot under the walk index
      logic flush;      // move held result to the output as the final one
      logic unmatched;  // emit the ack-unmatched result
      logic submit;     // perform a submit and emit its result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic report;     // current slot yields a result
      logic pend_valid; // a result is held back
      logic any_hit;    // an ack has matched at least one slot
      logic ack_op;     // item is an acknowledgement
      logic idx_last;   // walk index at the final slot
      logic out_free;   // output register can take a result this cycle
   } sts_type;

endpackage

### rtl/ack_retransmit_scheduler.sv
`timescale 1ns / 1ps

// Retransmission scheduler for messages awaiting acknowledgement.
// Input channel (req_*): one item per valid/stall handshake. func selects
// tick (walk the 8-slot table, transmit due slots with exponential backoff),
// submit (take the lowest free slot, stamp next sequence tag) or ack (free
// all slots with a matching tag). func 3 is dropped with no result.
// Result channel (rsp_*): zero or more items per input; rsp_last marks the
// final one. A tick with nothing due gives no result.
// Sequence: a submit is taken in idle and its result is written in the
// submit state; that result can be taken at the same edge as the next item.
// Tick and ack are taken in idle, walk the table one slot per step and end
// in a finish state that outputs the final result, which can be taken at
// the edge that takes the next item. A func 3 item ends in idle. The
// block takes one item at a time and req_stall is high until it is done.
// One result is held back so rsp_last can be set on the final one; a single
// output register sits before rsp_*.
// Receiver stall: rsp_* holds steady; the walk pauses whenever a new result
// would overwrite an untaken one, so nothing is lost.
// Reset (synchronous): all slots free, sequence tag zero, registers back to
// retry_start_ms = 500 and retry_max_ms = 8000, no result pending.
// CSR map: 0x0 retry_start_ms [15:0], 0x4 retry_max_ms [23:0].

module ack_retransmit_scheduler import ars_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // item in
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_func,
   input  logic [31:0]       req_now_ms,
   input  logic              req_link_ready,
   input  logic [3:0]        req_msg_type,
   input  logic [31:0]       req_ack_tag,
   // result out
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_kind,
   output logic [2:0]        rsp_slot,
   output logic [31:0]       rsp_tag,
   output logic [3:0]        rsp_out_type,
   output logic              rsp_is_retry,
   output logic              rsp_last,
   // config
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [15:0] retry_start_ff;
   logic [23:0] retry_max_ff;
   logic        reg_sel;
   cmd_type     cmd;
   sts_type     sts;
   res_type     rsp;

   // register index is the word address
   assign reg_sel = paddr[2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_start_ff <= RETRY_START_RESET;
         retry_max_ff   <= RETRY_MAX_RESET;
      end else if (psel && penable && pwrite) begin
         if (reg_sel == REG_RETRY_START) begin
            retry_start_ff <= pwdata[15:0];
         end else begin
            retry_max_ff <= pwdata[23:0];
         end
      end
   end

   always_comb begin
      if (reg_sel == REG_RETRY_MAX) begin
         prdata = {8'd0, retry_max_ff};
      end else begin
         prdata = {16'd0, retry_start_ff};
      end
   end

   ars_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ars_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_func       (req_func),
      .req_now_ms     (req_now_ms),
      .req_link_ready (req_link_ready),
      .req_msg_type   (req_msg_type),
      .req_ack_tag    (req_ack_tag),
      .retry_start    (retry_start_ff),
      .retry_max      (retry_max_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp            (rsp)
   );

   assign rsp_kind     = rsp.kind;
   assign rsp_slot     = rsp.slot;
   assign rsp_tag      = rsp.tag;
   assign rsp_out_type = rsp.out_type;
   assign rsp_is_retry = rsp.is_retry;
   assign rsp_last     = rsp.last;

endmodule

### rtl/ars_ctrl.sv
`timescale 1ns / 1ps

module ars_ctrl import ars_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_func,
   output logic       req_stall,
   output cmd_type    cmd,
   input  sts_type    sts
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SUBMIT = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_func == FUNC_SUBMIT) begin
                  state_in = ST_SUBMIT;
               end else if (req_func == FUNC_TICK || req_func == FUNC_ACK) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_SUBMIT: begin
            if (sts.out_free) begin
               cmd.submit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_WALK: begin
            // a new result pushes the held one out, which needs the output free
            if (!(sts.report && sts.pend_valid) || sts.out_free) begin
               cmd.step = 1'b1;
               if (sts.idx_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (sts.pend_valid) begin
               if (sts.out_free) begin
                  cmd.flush = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else if (sts.ack_op && !sts.any_hit) begin
               if (sts.out_free) begin
                  cmd.unmatched = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/ars_datapath.sv
`timescale 1ns / 1ps

module ars_datapath import ars_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_now_ms,
   input  logic        req_link_ready,
   input  logic [3:0]  req_msg_type,
   input  logic [31:0] req_ack_tag,
   input  logic [15:0] retry_start,
   input  logic [23:0] retry_max,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output res_type     rsp
);

   // latched item
   logic [1:0]  func_ff;
   logic [31:0] now_ff;
   logic        ready_ff;
   logic [3:0]  mtype_ff;
   logic [31:0] atag_ff;

   // slot table
   logic [SLOTS-1:0] used_ff;
   logic [31:0]      tag_ff   [SLOTS];
   logic [3:0]       type_ff  [SLOTS];
   logic [31:0]      due_ff   [SLOTS];
   logic [23:0]      delay_ff [SLOTS];
   logic             retry_ff [SLOTS];
   logic [31:0]      seq_ff;

   // walk and result holding
   logic [SLOT_W-1:0] idx_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              any_ff;
   logic              pend_valid_ff;
   res_type           pend_ff;
   logic              rsp_valid_ff;
   res_type           rsp_ff;

   logic              is_tick, is_ack;
   logic              cur_used, cur_retry;
   logic [31:0]       cur_tag, cur_due, due_diff, due_new, seq_next;
   logic [3:0]        cur_type;
   logic [23:0]       cur_delay, delay_new;
   logic [24:0]       delay_dbl;
   logic              match, room, report, retry_new, out_free, idx_last;
   logic [SLOT_W-1:0] free_idx;
   logic              free_found;
   res_type           pend_final;

   assign is_tick   = (func_ff == FUNC_TICK);
   assign is_ack    = (func_ff == FUNC_ACK);
   assign cur_used  = used_ff[idx_ff];
   assign cur_tag   = tag_ff[idx_ff];
   assign cur_type  = type_ff[idx_ff];
   assign cur_due   = due_ff[idx_ff];
   assign cur_delay = delay_ff[idx_ff];
   assign cur_retry = retry_ff[idx_ff];

   // due when now is at or past the due time, modulo 2^32
   assign due_diff  = now_ff - cur_due;
   assign match     = cur_used && (is_tick ? !due_diff[31] : (cur_tag == atag_ff));
   assign room      = (cnt_ff < CNT_W'(MAX_RESULTS));
   assign report    = match && room;
   assign retry_new = cur_retry || (cur_delay > {8'd0, retry_start});
   assign due_new   = now_ff + {8'd0, cur_delay};
   assign delay_dbl = {cur_delay, 1'b0};
   assign delay_new = (delay_dbl > {1'b0, retry_max}) ? retry_max : delay_dbl[23:0];
   assign seq_next  = seq_ff + 32'd1;
   assign idx_last  = (idx_ff == SLOT_W'(SLOTS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // held result marked as the final one
   always_comb begin
      pend_final      = pend_ff;
      pend_final.last = 1'b1;
   end

   // lowest free slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx   = SLOT_W'(i);
            free_found = 1'b1;
         end
      end
   end

   assign sts.report     = report;
   assign sts.pend_valid = pend_valid_ff;
   assign sts.any_hit    = any_ff;
   assign sts.ack_op     = is_ack;
   assign sts.idx_last   = idx_last;
   assign sts.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         seq_ff        <= '0;
         idx_ff        <= '0;
         cnt_ff        <= '0;
         any_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if ((cmd.step && report && pend_valid_ff) || cmd.flush || cmd.unmatched ||
             cmd.submit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.load) begin
            idx_ff        <= '0;
            cnt_ff        <= '0;
            any_ff        <= 1'b0;
            pend_valid_ff <= 1'b0;
         end
         if (cmd.step) begin
            idx_ff <= idx_last ? '0 : idx_ff + SLOT_W'(1);
            if (match) begin
               any_ff <= 1'b1;
               if (is_ack) begin
                  used_ff[idx_ff] <= 1'b0;
               end
            end
            if (report) begin
               pend_valid_ff <= 1'b1;
               cnt_ff        <= cnt_ff + CNT_W'(1);
            end
         end
         if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.submit) begin
            if (free_found && ready_ff) begin
               used_ff[free_idx] <= 1'b1;
               seq_ff            <= seq_next;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         now_ff   <= req_now_ms;
         ready_ff <= req_link_ready;
         mtype_ff <= req_msg_type;
         atag_ff  <= req_ack_tag;
      end
      if (cmd.step && report) begin
         // held result is never the final one here
         if (pend_valid_ff) begin
            rsp_ff <= pend_ff;
         end
         pend_ff.kind     <= is_tick ? KIND_TRANSMIT : KIND_ACK_MATCH;
         pend_ff.slot     <= 3'(idx_ff);
         pend_ff.tag      <= cur_tag;
         pend_ff.out_type <= cur_type;
         pend_ff.is_retry <= is_tick && retry_new;
         pend_ff.last     <= 1'b0;
         if (is_tick) begin
            retry_ff[idx_ff] <= retry_new;
            due_ff[idx_ff]   <= due_new;
            delay_ff[idx_ff] <= delay_new;
         end
      end
      if (cmd.flush) begin
         rsp_ff <= pend_final;
      end
      if (cmd.unmatched) begin
         rsp_ff.kind     <= KIND_ACK_NONE;
         rsp_ff.slot     <= '0;
         rsp_ff.tag      <= atag_ff;
         rsp_ff.out_type <= '0;
         rsp_ff.is_retry <= 1'b0;
         rsp_ff.last     <= 1'b1;
      end
      if (cmd.submit) begin
         rsp_ff.is_retry <= 1'b0;
         rsp_ff.last     <= 1'b1;
         rsp_ff.out_type <= mtype_ff;
         if (free_found && ready_ff) begin
            tag_ff[free_idx]   <= seq_next;
            type_ff[free_idx]  <= mtype_ff;
            due_ff[free_idx]   <= now_ff;
            delay_ff[free_idx] <= {8'd0, retry_start};
            retry_ff[free_idx] <= 1'b0;
            rsp_ff.kind        <= KIND_ACCEPTED;
            rsp_ff.slot        <= 3'(free_idx);
            rsp_ff.tag         <= seq_next;
         end else begin
            rsp_ff.kind <= KIND_REJECTED;
            rsp_ff.slot <= '0;
            rsp_ff.tag  <= '0;
         end
      end
   end

`ifndef ASSERT_OFF
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && report && pend_valid_ff) |-> out_free)
      else $error("held result pushed while output busy");

   a_load_clears_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (!pend_valid_ff && cnt_ff == '0))
      else $error("walk not restarted on new item");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      (cmd.submit && free_found && ready_ff) |=> (seq_ff == $past(seq_ff) + 32'd1))
      else $error("sequence tag did not advance on accepted submit");

   a_flush_final: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (rsp_valid_ff && rsp_ff.last))
      else $error("flushed result not marked final");
`endif

endmodule

### verif/ack_retransmit_scheduler_tb.sv
`timescale 1ns / 1ps

module ack_retransmit_scheduler_tb;
   import ars_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int DRAIN_CYCLES = 40;          // walk of 8 slots plus flush, with margin
   localparam int SEG_ITEMS    = 50;          // items per random segment
   localparam int NUM_SEGS     = 6;
   localparam longint LIMIT_NS = 5_000_000;   // overall time limit of the run, in ns

   // func value the block drops without a result
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // CSR byte addresses: register index times four
   localparam logic [ADDR_W-1:0] ADDR_RETRY_START = {REG_RETRY_START, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_RETRY_MAX   = {REG_RETRY_MAX, 2'b00};

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] now_ms;
      logic        link_ready;
      logic [3:0]  msg_type;
      logic [31:0] ack_tag;
   } msg_req_type;

   // one line of the directed table; res is meaningful only when typed is set
   typedef struct packed {
      msg_req_type req;
      logic        typed;
      res_type     res;
   } stim_row_type;

   // shadow of one table entry
   typedef struct packed {
      logic        used;
      logic [31:0] tag;
      logic [3:0]  mtype;
      logic [31:0] due;
      logic [23:0] delay;
      logic        retry;
   } slot_rec_type;

   logic clock;
   logic reset;

   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [31:0] req_now_ms;
   logic        req_link_ready;
   logic [3:0]  req_msg_type;
   logic [31:0] req_ack_tag;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [2:0]  rsp_slot;
   logic [31:0] rsp_tag;
   logic [3:0]  rsp_out_type;
   logic        rsp_is_retry;
   logic        rsp_last;

   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   // item currently offered, plus its typed-in expectation for directed rows
   msg_req_type req_item;
   logic        row_typed;
   res_type     row_res;

   assign req_func       = req_item.func;
   assign req_now_ms     = req_item.now_ms;
   assign req_link_ready = req_item.link_ready;
   assign req_msg_type   = req_item.msg_type;
   assign req_ack_tag    = req_item.ack_tag;

   // scheduler shadow state
   slot_rec_type slot_tbl [SLOTS];
   logic [31:0]  tag_count;
   logic [15:0]  cfg_start;
   logic [23:0]  cfg_max;

   res_type step_reports[$];   // results of the item just accepted
   res_type owed_reports[$];   // results still to come out of the block
   res_type seen_rep, want_rep;

   logic [31:0] ms_clock;      // stimulus notion of the millisecond time
   int src_gap_pct, sink_stall_pct;
   int err_count = 0;
   int n_tick = 0, n_submit = 0, n_ack = 0, n_ignored = 0;
   int n_results = 0, n_resends = 0, n_settings = 0;

   ack_retransmit_scheduler DUT (.*);

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_NS);
      $display("%0t: run timed out with %0d results outstanding", $time, owed_reports.size());
      $display("Some tests failed");
      $finish;
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) rsp_stall = ($urandom_range(99) < sink_stall_pct);

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         err_count++;
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   task automatic compare_report(input string what, input res_type want, input res_type got);
      check_field({what, " kind"}, want.kind, got.kind);
      check_field({what, " slot"}, want.slot, got.slot);
      check_field({what, " tag"}, want.tag, got.tag);
      check_field({what, " out_type"}, want.out_type, got.out_type);
      check_field({what, " is_retry"}, want.is_retry, got.is_retry);
      check_field({what, " last"}, want.last, got.last);
   endtask

   // Shadow scheduler: updates the table for one item and leaves its results
   // in step_reports, last flag set on the final one.
   task automatic advance_schedule(input msg_req_type r);
      res_type     rep;
      logic [31:0] age;
      logic [24:0] dbl;
      int          hit;
      logic        any;
      step_reports.delete();
      hit = -1;
      any = 1'b0;
      case (r.func)
         FUNC_TICK: begin
            for (int i = 0; i < SLOTS; i++) begin
               // due when now is at or past the due time, modulo 2^32
               age = r.now_ms - slot_tbl[i].due;
               if (slot_tbl[i].used && !age[31] && step_reports.size() < MAX_RESULTS) begin
                  // retry mark is sticky until the slot is freed
                  if ({8'b0, slot_tbl[i].delay} > {16'b0, cfg_start})
                     slot_tbl[i].retry = 1'b1;
                  rep = '0;
                  rep.kind     = KIND_TRANSMIT;
                  rep.slot     = i[2:0];
                  rep.tag      = slot_tbl[i].tag;
                  rep.out_type = slot_tbl[i].mtype;
                  rep.is_retry = slot_tbl[i].retry;
                  step_reports.push_back(rep);
                  slot_tbl[i].due = r.now_ms + {8'b0, slot_tbl[i].delay};
                  dbl = {slot_tbl[i].delay, 1'b0};
                  slot_tbl[i].delay = (dbl > {1'b0, cfg_max}) ? cfg_max : dbl[23:0];
               end
            end
         end
         FUNC_SUBMIT: begin
            for (int i = 0; i < SLOTS; i++)
               if (!slot_tbl[i].used && hit < 0) hit = i;
            rep = '0;
            rep.out_type = r.msg_type;
            if (hit < 0 || !r.link_ready) begin
               rep.kind = KIND_REJECTED;
            end else begin
               tag_count = tag_count + 32'd1;
               slot_tbl[hit].used  = 1'b1;
               slot_tbl[hit].tag   = tag_count;
               slot_tbl[hit].mtype = r.msg_type;
               slot_tbl[hit].due   = r.now_ms;   // due at once
               slot_tbl[hit].delay = {8'b0, cfg_start};
               slot_tbl[hit].retry = 1'b0;
               rep.kind = KIND_ACCEPTED;
               rep.slot = hit[2:0];
               rep.tag  = tag_count;
            end
            step_reports.push_back(rep);
         end
         FUNC_ACK: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_tbl[i].used && slot_tbl[i].tag == r.ack_tag) begin
                  slot_tbl[i].used = 1'b0;
                  any = 1'b1;
                  if (step_reports.size() < MAX_RESULTS) begin
                     rep = '0;
                     rep.kind     = KIND_ACK_MATCH;
                     rep.slot     = i[2:0];
                     rep.tag      = slot_tbl[i].tag;
                     rep.out_type = slot_tbl[i].mtype;
                     step_reports.push_back(rep);
                  end
               end
            end
            if (!any) begin
               rep = '0;
               rep.kind = KIND_ACK_NONE;
               rep.tag  = r.ack_tag;
               step_reports.push_back(rep);
            end
         end
         default: ;
      endcase
      if (step_reports.size() > 0) begin
         rep = step_reports.pop_back();
         rep.last = 1'b1;
         step_reports.push_back(rep);
      end
   endtask

   // Result checking and prediction, both on the rising edge. Results are
   // checked first: none can come from an item accepted on this same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_rep = {rsp_kind, rsp_slot, rsp_tag, rsp_out_type, rsp_is_retry, rsp_last};
            n_results++;
            if (seen_rep.is_retry) n_resends++;
            if (owed_reports.size() == 0) begin
               err_count++;
               $display("%0t: unexpected result: expected none, got kind %0d slot %0d tag %0h",
                        $time, seen_rep.kind, seen_rep.slot, seen_rep.tag);
            end else begin
               want_rep = owed_reports.pop_front();
               compare_report("result", want_rep, seen_rep);
            end
         end
         if (req_valid && !req_stall) begin
            advance_schedule(req_item);
            case (req_item.func)
               FUNC_TICK:   n_tick++;
               FUNC_SUBMIT: n_submit++;
               FUNC_ACK:    n_ack++;
               default:     n_ignored++;
            endcase
            if (row_typed) begin
               // hand-written expectation stands; the shadow must agree with it
               if (step_reports.size() != 1) begin
                  err_count++;
                  $display("%0t: directed row result count: expected 1, got %0d",
                           $time, step_reports.size());
               end else begin
                  want_rep = step_reports[0];
                  compare_report("directed row", row_res, want_rep);
               end
               owed_reports.push_back(row_res);
            end else begin
               foreach (step_reports[i]) owed_reports.push_back(step_reports[i]);
            end
         end
      end
   end

   // Offer one item, with a random idle gap ahead of it, and hold it until
   // taken. Returns at the falling edge after the accepting edge.
   task automatic send_item(input msg_req_type item, input logic typed, input res_type res);
      while ($urandom_range(99) < src_gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_item  = item;
      row_typed = typed;
      row_res   = res;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // APB transfer: setup cycle, then access until pready
   task automatic csr_access(input logic wr, input logic [ADDR_W-1:0] addr,
                             input logic [31:0] data, output logic [31:0] rd);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic check_timers(input logic [15:0] start, input logic [23:0] cap);
      logic [31:0] rd;
      csr_access(1'b0, ADDR_RETRY_START, 32'd0, rd);
      check_field("retry_start_ms readback", {16'b0, start}, rd);
      csr_access(1'b0, ADDR_RETRY_MAX, 32'd0, rd);
      check_field("retry_max_ms readback", {8'b0, cap}, rd);
   endtask

   // Write both timers; upper bus bits carry junk the block must drop.
   task automatic set_timers(input logic [15:0] start, input logic [23:0] cap,
                             input logic [15:0] junk);
      logic [31:0] rd;
      csr_access(1'b1, ADDR_RETRY_START, {junk, start}, rd);
      csr_access(1'b1, ADDR_RETRY_MAX, {junk[7:0], cap}, rd);
      cfg_start = start;
      cfg_max   = cap;
      n_settings++;
      check_timers(start, cap);
   endtask

   // Let every owed result come out, then give the walk time to settle so a
   // trailing item with no result is done before any register write.
   task automatic finish_phase();
      req_valid = 1'b0;
      while (owed_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random traffic: mostly ticks, submits and acks of live tags, with time
   // advancing on a log scale so every backoff step gets reached, and the
   // odd jump to an arbitrary time or an ignored func code.
   task automatic random_item(output msg_req_type r);
      logic [31:0] live[$];
      int pick;
      pick = $urandom_range(99);
      if ($urandom_range(19) == 0)
         ms_clock = $urandom;
      else
         ms_clock = ms_clock + $urandom_range(0, 1 << $urandom_range(0, 24));
      r.now_ms     = ms_clock;
      r.link_ready = ($urandom_range(99) < 85);
      r.msg_type   = 4'($urandom_range(15));
      r.ack_tag    = $urandom;
      if (pick < 40) begin
         r.func = FUNC_TICK;
      end else if (pick < 65) begin
         r.func = FUNC_SUBMIT;
      end else if (pick < 95) begin
         r.func = FUNC_ACK;
         foreach (slot_tbl[i])
            if (slot_tbl[i].used) live.push_back(slot_tbl[i].tag);
         pick = $urandom_range(99);
         if (pick < 70 && live.size() > 0)
            r.ack_tag = live[$urandom_range(live.size() - 1)];
         else if (pick < 85)
            r.ack_tag = tag_count - $urandom_range(3);   // recent, often already freed
      end else begin
         r.func = FUNC_UNUSED;
      end
   endtask

   function automatic stim_row_type row(input logic [1:0] f, input logic [31:0] now,
                                        input logic rdy, input logic [3:0] mt,
                                        input logic [31:0] at, input logic typed,
                                        input logic [2:0] k, input logic [2:0] s,
                                        input logic [31:0] t, input logic [3:0] ot);
      stim_row_type x;
      x.req.func       = f;
      x.req.now_ms     = now;
      x.req.link_ready = rdy;
      x.req.msg_type   = mt;
      x.req.ack_tag    = at;
      x.typed          = typed;
      x.res            = '0;
      x.res.kind       = k;
      x.res.slot       = s;
      x.res.tag        = t;
      x.res.out_type   = ot;
      x.res.last       = 1'b1;
      return x;
   endfunction

   // row left to the shadow model
   function automatic stim_row_type bare(input logic [1:0] f, input logic [31:0] now,
                                         input logic rdy, input logic [3:0] mt,
                                         input logic [31:0] at);
      return row(f, now, rdy, mt, at, 1'b0, KIND_TRANSMIT, 3'd0, 32'd0, 4'd0);
   endfunction

   initial begin
      stim_row_type directed_rows[$];
      stim_row_type cur;
      msg_req_type  item;
      logic [15:0]  seg_start [NUM_SEGS];
      logic [23:0]  seg_max [NUM_SEGS];
      int           issued;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      row_typed = 1'b0;
      row_res   = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = 32'd0;
      foreach (slot_tbl[i]) slot_tbl[i] = '0;
      tag_count      = 32'd0;
      cfg_start      = RETRY_START_RESET;
      cfg_max        = RETRY_MAX_RESET;
      src_gap_pct    = 7;
      sink_stall_pct = 78;
      ms_clock       = 32'h9000_0000;

      // Directed part, run with the reset timers (500 / 8000).
      // Empty table: tick gives nothing, acks go unmatched.
      directed_rows.push_back(bare(FUNC_TICK, 32'd0, 1'b1, 4'h0, 32'd0));
      directed_rows.push_back(row(FUNC_ACK, 32'h1234, 1'b1, 4'hA, 32'd0,
                                  1'b1, KIND_ACK_NONE, 3'd0, 32'd0, 4'h0));
      directed_rows.push_back(row(FUNC_ACK, 32'hFFFF_FFFF, 1'b0, 4'hF, 32'hFFFF_FFFF,
                                  1'b1, KIND_ACK_NONE, 3'd0, 32'hFFFF_FFFF, 4'h0));
      // link down: rejected, tag counter holds
      directed_rows.push_back(row(FUNC_SUBMIT, 32'd0, 1'b0, 4'hF, 32'hFFFF_FFFF,
                                  1'b1, KIND_REJECTED, 3'd0, 32'd0, 4'hF));
      // unknown func, all ones everywhere: dropped
      directed_rows.push_back(bare(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'hFFFF_FFFF));
      directed_rows.push_back(row(FUNC_SUBMIT, 32'd0, 1'b1, 4'h0, 32'd0,
                                  1'b1, KIND_ACCEPTED, 3'd0, 32'd1, 4'h0));
      directed_rows.push_back(row(FUNC_SUBMIT, 32'hFFFF_FFF0, 1'b1, 4'hF, 32'd0,
                                  1'b1, KIND_ACCEPTED, 3'd1, 32'd2, 4'hF));
      // due time across the 32-bit wrap, then first retransmit, then a tick
      // right at the edge of the half-range due window
      directed_rows.push_back(bare(FUNC_TICK, 32'd0, 1'b1, 4'h0, 32'd0));
      directed_rows.push_back(bare(FUNC_TICK, 32'd499, 1'b1, 4'h0, 32'd0));
      directed_rows.push_back(bare(FUNC_TICK, 32'h8000_01F3, 1'b0, 4'h0, 32'd0));
      // fill the table
      for (int k = 2; k < SLOTS; k++)
         directed_rows.push_back(row(FUNC_SUBMIT, 32'h8000_0000, 1'b1, 4'(k + 6), 32'd0,
                                     1'b1, KIND_ACCEPTED, 3'(k), 32'(k + 1), 4'(k + 6)));
      // table full: rejected even with the link up
      directed_rows.push_back(row(FUNC_SUBMIT, 32'h8000_0000, 1'b1, 4'h3, 32'd0,
                                  1'b1, KIND_REJECTED, 3'd0, 32'd0, 4'h3));
      // every slot due at once: eight results from one tick
      directed_rows.push_back(bare(FUNC_TICK, 32'h8001_0000, 1'b1, 4'h0, 32'd0));
      // ack a tag, ack it again, reuse the slot, ack the top slot
      directed_rows.push_back(row(FUNC_ACK, 32'd0, 1'b1, 4'h0, 32'd1,
                                  1'b1, KIND_ACK_MATCH, 3'd0, 32'd1, 4'h0));
      directed_rows.push_back(row(FUNC_ACK, 32'd0, 1'b1, 4'h0, 32'd1,
                                  1'b1, KIND_ACK_NONE, 3'd0, 32'd1, 4'h0));
      directed_rows.push_back(row(FUNC_SUBMIT, 32'h8001_0000, 1'b1, 4'h5, 32'd0,
                                  1'b1, KIND_ACCEPTED, 3'd0, 32'd9, 4'h5));
      directed_rows.push_back(row(FUNC_ACK, 32'd0, 1'b0, 4'h0, 32'd8,
                                  1'b1, KIND_ACK_MATCH, 3'd7, 32'd8, 4'hD));
      // repeated ticks: delays reach the cap, retry mark stays set
      directed_rows.push_back(bare(FUNC_TICK, 32'h8010_0000, 1'b1, 4'h0, 32'd0));
      directed_rows.push_back(bare(FUNC_TICK, 32'h8100_0000, 1'b1, 4'h0, 32'd0));
      directed_rows.push_back(bare(FUNC_TICK, 32'h9000_0000, 1'b1, 4'h0, 32'd0));

      // timer settings per random segment: extremes, zero delay, random
      seg_start[0] = 16'd1;           seg_max[0] = 24'hFF_FFFF;
      seg_start[1] = 16'hFFFF;        seg_max[1] = 24'd1;        // cap below start
      seg_start[2] = 16'd0;           seg_max[2] = 24'd0;        // zero delay, zero cap
      seg_start[3] = 16'($urandom_range(1, 16'hFFFF));
      seg_max[3]   = 24'($urandom_range(1, 24'hFF_FFFF));
      seg_start[4] = 16'hFFFF;        seg_max[4] = 24'hFF_FFFF;
      seg_start[5] = 16'($urandom_range(1, 50));
      seg_max[5]   = 24'($urandom_range(1, 2000));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      check_timers(RETRY_START_RESET, RETRY_MAX_RESET);

      for (int i = 0; i < directed_rows.size(); i++) begin
         cur = directed_rows[i];
         send_item(cur.req, cur.typed, cur.res);
      end
      finish_phase();

      // Random segments: sender eager / receiver busy, then the reverse,
      // then both flat out.
      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         case (seg / 2)
            0:       begin src_gap_pct = 7;  sink_stall_pct = 78; end
            1:       begin src_gap_pct = 78; sink_stall_pct = 7;  end
            default: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
         endcase
         set_timers(seg_start[seg], seg_max[seg], 16'($urandom));
         issued = 0;
         while (issued < SEG_ITEMS) begin
            random_item(item);
            send_item(item, 1'b0, '0);
            issued++;
         end
         finish_phase();
      end

      if (owed_reports.size() != 0) begin
         err_count += owed_reports.size();
         $display("%0t: %0d expected results never arrived", $time, owed_reports.size());
      end

      $display("Covered %0d ticks, %0d submits, %0d acks, %0d dropped items;",
               n_tick, n_submit, n_ack, n_ignored);
      $display("%0d results (%0d resends); reset timers plus %0d written pairs.",
               n_results, n_resends, n_settings);
      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### files.f
rtl/ars_pkg.sv
rtl/ars_ctrl.sv
rtl/ars_datapath.sv
rtl/ack_retransmit_scheduler.sv
verif/ack_retransmit_scheduler_tb.sv
